@@ rtl/ssp_pkg.sv @@
`default_nettype none

package ssp_pkg;

  localparam int VALUE_BITS = 63;  // accumulator width, 16 to 63
  localparam int CH_W       = 8;
  localparam int SIZE_W     = 63;
  localparam int STATUS_W   = 3;
  localparam int SHIFT_W    = 6;

  localparam logic [SIZE_W-1:0] SIZE_LIMIT_RESET = '1;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  // Clearing bit 5 folds a..z onto A..Z; only the letters map onto K, M, G, T, P.
  localparam logic [CH_W-1:0] CASE_MASK = 8'hDF;
  localparam logic [CH_W-1:0] CH_K = 8'h4B;
  localparam logic [CH_W-1:0] CH_M = 8'h4D;
  localparam logic [CH_W-1:0] CH_G = 8'h47;
  localparam logic [CH_W-1:0] CH_T = 8'h54;
  localparam logic [CH_W-1:0] CH_P = 8'h50;

  localparam logic [SHIFT_W-1:0] SH_NONE = 6'd0;
  localparam logic [SHIFT_W-1:0] SH_K    = 6'd10;
  localparam logic [SHIFT_W-1:0] SH_M    = 6'd20;
  localparam logic [SHIFT_W-1:0] SH_G    = 6'd30;
  localparam logic [SHIFT_W-1:0] SH_T    = 6'd40;
  localparam logic [SHIFT_W-1:0] SH_P    = 6'd50;

  localparam logic [1:0] TAIL_NONE = 2'd0;
  localparam logic [1:0] TAIL_ONE  = 2'd1;
  localparam logic [1:0] TAIL_MANY = 2'd2;

  typedef enum logic [3:0] {
    PH_WS     = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_TAIL   = 4'b1000
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_NUMBER = 3'd1,
    ST_BAD_SUFFIX = 3'd2,
    ST_SUFFIX_OVF = 3'd3,
    ST_EXTRA      = 3'd4,
    ST_OVER_MAX   = 3'd5
  } status_t;

  typedef struct packed {
    phase_t                phase;
    logic [VALUE_BITS-1:0] acc;
    logic                  negative;
    logic                  overflowed;
    logic                  digit_seen;
    logic [1:0]            tail_count;
    logic [CH_W-1:0]       suffix_char;
  } parse_state_t;

  localparam parse_state_t PARSE_IDLE = '{
    phase:       PH_WS,
    acc:         '0,
    negative:    1'b0,
    overflowed:  1'b0,
    digit_seen:  1'b0,
    tail_count:  TAIL_NONE,
    suffix_char: CH_NUL
  };

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

@@ rtl/ssp_in_if.sv @@
`default_nettype none

interface ssp_in_if;
  logic                      valid;
  logic                      ready;
  logic [ssp_pkg::CH_W-1:0]  ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

@@ rtl/ssp_out_if.sv @@
`default_nettype none

interface ssp_out_if;
  logic                          valid;
  logic                          ready;
  logic [ssp_pkg::SIZE_W-1:0]    size_bytes;
  logic [ssp_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output size_bytes, output status, input ready);
  modport sink   (input valid, input size_bytes, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/ssp_cfg_if.sv @@
`default_nettype none

interface ssp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ssp_pkg::SIZE_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/ssp_scan.sv @@
`default_nettype none

module ssp_scan (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  logic [ssp_pkg::CH_W-1:0] ch,
  output ssp_pkg::parse_state_t   state
);
  import ssp_pkg::*;

  parse_state_t          state_next;
  logic [3:0]            digit;
  logic [VALUE_BITS+3:0] prod;
  logic                  prod_ovf;
  logic                  take_digit;
  logic                  take_tail;
  logic                  term;

  assign term = (ch == CH_NUL);

  // acc*10 + d; anything above VALUE_BITS means the magnitude no longer fits
  always_comb begin
    digit    = ch[3:0];
    prod     = ({4'b0, state.acc} << 3) + ({4'b0, state.acc} << 1)
             + (VALUE_BITS+4)'(digit);
    prod_ovf = |prod[VALUE_BITS+3:VALUE_BITS];
  end

  always_comb begin
    state_next = state;
    take_digit = 1'b0;
    take_tail  = 1'b0;
    unique case (state.phase)
      PH_WS: begin
        if (is_space(ch)) begin
          take_digit = 1'b0;
        end else if ((ch == CH_PLUS) || (ch == CH_MINUS)) begin
          state_next.negative = (ch == CH_MINUS);
          state_next.phase    = PH_SIGN;
        end else if (is_digit(ch)) begin
          take_digit = 1'b1;
        end else begin
          take_tail = 1'b1;
        end
      end
      PH_SIGN, PH_DIGITS: begin
        if (is_digit(ch)) begin
          take_digit = 1'b1;
        end else begin
          take_tail = 1'b1;
        end
      end
      default: begin
        take_tail = 1'b1;
      end
    endcase

    if (take_digit) begin
      state_next.phase      = PH_DIGITS;
      state_next.digit_seen = 1'b1;
      if (!state.overflowed) begin
        if (prod_ovf) begin
          state_next.overflowed = 1'b1;
        end else begin
          state_next.acc = prod[VALUE_BITS-1:0];
        end
      end
    end

    if (take_tail) begin
      state_next.phase = PH_TAIL;
      if (state.tail_count == TAIL_NONE) begin
        state_next.suffix_char = ch;
      end
      if (state.tail_count != TAIL_MANY) begin
        state_next.tail_count = state.tail_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && term)) begin
      state <= PARSE_IDLE;
    end else if (fire) begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_term: assert property (@(posedge clk) disable iff (rst)
    fire && term |=> (state.phase == PH_WS) && (state.acc == '0)
                     && (state.tail_count == TAIL_NONE))
    else $error("parse state not cleared after terminator");
`endif

endmodule

`default_nettype wire

@@ rtl/ssp_finish.sv @@
`default_nettype none

module ssp_finish (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  ssp_pkg::parse_state_t      state,
  input  logic [ssp_pkg::SIZE_W-1:0] size_limit,
  ssp_out_if.source                  result
);
  import ssp_pkg::*;

  logic [SIZE_W-1:0]  value;
  logic [CH_W-1:0]    upper;
  logic [SHIFT_W-1:0] sh;
  logic [SHIFT_W-1:0] eff_sh;
  logic               suffix_ok;
  logic               bad_num;
  logic [SIZE_W-1:0]  lim_sh;
  logic               exceeds;
  status_t            status_next;
  logic [SIZE_W-1:0]  size_next;

  always_comb begin
    value     = SIZE_W'(state.acc);
    upper     = state.suffix_char & CASE_MASK;
    suffix_ok = 1'b1;
    unique case (upper)
      CH_K:    sh = SH_K;
      CH_M:    sh = SH_M;
      CH_G:    sh = SH_G;
      CH_T:    sh = SH_T;
      CH_P:    sh = SH_P;
      default: begin
        sh        = SH_NONE;
        suffix_ok = 1'b0;
      end
    endcase
    eff_sh  = (state.tail_count == TAIL_ONE) ? sh : SH_NONE;
    // value <= (limit >> sh) already implies (value << sh) <= limit
    lim_sh  = size_limit >> eff_sh;
    exceeds = value > lim_sh;
    bad_num = !state.digit_seen || state.overflowed
              || (state.negative && (state.acc != '0));

    priority if (bad_num) begin
      status_next = ST_BAD_NUMBER;
    end else if (state.tail_count == TAIL_MANY) begin
      status_next = ST_EXTRA;
    end else if ((state.tail_count == TAIL_ONE) && !suffix_ok) begin
      status_next = ST_BAD_SUFFIX;
    end else if (exceeds && (state.tail_count == TAIL_ONE)) begin
      status_next = ST_SUFFIX_OVF;
    end else if (exceeds) begin
      status_next = ST_OVER_MAX;
    end else begin
      status_next = ST_OK;
    end

    size_next = (status_next == ST_OK) ? (value << eff_sh) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.size_bytes <= size_next;
      result.status     <= status_next;
    end
  end

`ifndef SYNTHESIS
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> result.valid)
    else $error("terminator did not produce a result");
  a_err_zero_size: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status != ST_OK) |-> (result.size_bytes == '0))
    else $error("nonzero size with error status");
`endif

endmodule

`default_nettype wire

@@ rtl/size_suffix_parser_core.sv @@
// Channel  Dir  Payload                     Transfer
// chars    in   ch[7:0]                     valid & ready
// result   out  size_bytes[62:0], status    valid & ready
// cfg      in   data[62:0] -> size_limit    valid & ready (always ready)
//
// One byte per cycle while no zero byte stalls. A zero byte passes through the
// input register, and its result is then loaded into the result register.
// Reset clears the parse state and sets size_limit to 2^63-1. Only a zero
// byte can stall, and only while an earlier result is untaken; other bytes
// keep flowing past a waiting result.
`default_nettype none

module size_suffix_parser_core (
  input  logic      clk,
  input  logic      rst,
  ssp_in_if.sink    chars,
  ssp_out_if.source result,
  ssp_cfg_if.sink   cfg
);
  import ssp_pkg::*;

  logic              a_valid;
  logic [CH_W-1:0]   ch_q;
  logic [SIZE_W-1:0] size_limit;
  logic              term;
  logic              out_free;
  logic              fire;
  logic              load;
  parse_state_t      state;

  assign term        = (ch_q == CH_NUL);
  assign out_free    = !result.valid || result.ready;
  assign fire        = a_valid && (!term || out_free);
  assign load        = fire && term;
  assign chars.ready = !a_valid || fire;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (chars.ready) begin
      a_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      ch_q <= chars.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= SIZE_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      size_limit <= cfg.data;
    end
  end

  ssp_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .ch    (ch_q),
    .state (state)
  );

  ssp_finish u_finish (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .state      (state),
    .size_limit (size_limit),
    .result     (result)
  );

`ifndef SYNTHESIS
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    a_valid && !fire |=> a_valid && $stable(ch_q))
    else $error("held input byte lost");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> out_free)
    else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

@@ tb/size_suffix_parser_core_test.sv @@
`timescale 1ns / 1ps

module size_suffix_parser_core_test;
  import ssp_pkg::*;

  localparam int TEXT_LEN        = 24;
  localparam int DIR_ROWS        = 30;
  localparam int RAND_PHASES     = 6;
  localparam int PHASE_CHARS     = 120;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_CYCLES = 3000;

  localparam logic [SIZE_W-1:0] SIZE_MAX  = '1;
  localparam logic [63:0]       MAG_LIMIT = (64'd1 << VALUE_BITS) - 64'd1;
  // low byte first: K M G T P, then the lower-case letters
  localparam logic [79:0]     SUFFIX_SET = "ptgmkPTGMK";
  localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CH_W-1:0] CASE_GAP   = 8'h20;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    status_t           st;
  } size_res_t;

  typedef struct packed {
    logic      fixed;
    size_res_t res;
  } pinned_res_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [8*TEXT_LEN-1:0] text;
    logic                  fixed;
    logic [SIZE_W-1:0]     size;
    status_t               st;
  } dir_row_t;

  // Text is right-aligned; cfg rows carry the new size limit in the size column.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{1'b0, "",                        1'b1, 63'd0,               ST_BAD_NUMBER},
    '{1'b0, "0",                       1'b1, 63'd0,               ST_OK},
    '{1'b0, "9223372036854775807",     1'b1, SIZE_MAX,            ST_OK},
    '{1'b0, "9223372036854775808",     1'b1, 63'd0,               ST_BAD_NUMBER},
    '{1'b0, " \011\012\013\014\015+12", 1'b1, 63'd12,             ST_OK},
    '{1'b0, "-0",                      1'b1, 63'd0,               ST_OK},
    '{1'b0, "-5",                      1'b1, 63'd0,               ST_BAD_NUMBER},
    '{1'b0, "+",                       1'b1, 63'd0,               ST_BAD_NUMBER},
    '{1'b0, "1k",                      1'b1, 63'd1024,            ST_OK},
    '{1'b0, "1M",                      1'b1, 63'd1048576,         ST_OK},
    '{1'b0, "1g",                      1'b1, 63'd1073741824,      ST_OK},
    '{1'b0, "1T",                      1'b1, 63'd1099511627776,   ST_OK},
    '{1'b0, "1p",                      1'b1, 63'd1125899906842624, ST_OK},
    '{1'b0, "8191P",                   1'b0, 63'd0,               ST_OK},
    '{1'b0, "8192p",                   1'b1, 63'd0,               ST_SUFFIX_OVF},
    '{1'b0, "1x",                      1'b1, 63'd0,               ST_BAD_SUFFIX},
    '{1'b0, "1KB",                     1'b1, 63'd0,               ST_EXTRA},
    '{1'b0, "12 ",                     1'b1, 63'd0,               ST_BAD_SUFFIX},
    '{1'b0, "+-3",                     1'b1, 63'd0,               ST_BAD_NUMBER},
    '{1'b0, "12-3",                    1'b1, 63'd0,               ST_EXTRA},
    '{1'b0, "\377\200",                1'b1, 63'd0,               ST_BAD_NUMBER},
    '{1'b0, "0000000000000000000042m", 1'b0, 63'd0,               ST_OK},
    '{1'b0, "  -0K",                   1'b0, 63'd0,               ST_OK},
    '{1'b1, "",                        1'b0, 63'd1000,            ST_OK},
    '{1'b0, "1000",                    1'b1, 63'd1000,            ST_OK},
    '{1'b0, "1001",                    1'b1, 63'd0,               ST_OVER_MAX},
    '{1'b0, "1k",                      1'b1, 63'd0,               ST_SUFFIX_OVF},
    '{1'b1, "",                        1'b0, 63'd0,               ST_OK},
    '{1'b0, "0P",                      1'b1, 63'd0,               ST_OK},
    '{1'b0, "1",                       1'b1, 63'd0,               ST_OVER_MAX}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  ssp_in_if  chars_if ();
  ssp_out_if result_if ();
  ssp_cfg_if cfg_if ();

  size_suffix_parser_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // parser state as seen by the predictor
  phase_t                parse_phase;
  logic [VALUE_BITS-1:0] parse_mag;
  logic                  parse_neg;
  logic                  parse_ovf;
  logic                  parse_digit;
  logic [1:0]            parse_tail;
  logic [CH_W-1:0]       parse_suffix;
  logic [SIZE_W-1:0]     size_limit_m;

  logic [CH_W-1:0] char_q [$];
  pinned_res_t     pinned_q [$];
  size_res_t       size_q [$];
  int              mismatches = 0;

  function automatic logic is_blank(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_numeral(input logic [CH_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic parse_clear();
    parse_phase  = PH_WS;
    parse_mag    = '0;
    parse_neg    = 1'b0;
    parse_ovf    = 1'b0;
    parse_digit  = 1'b0;
    parse_tail   = TAIL_NONE;
    parse_suffix = CH_NUL;
  endtask

  task automatic add_digit(input logic [CH_W-1:0] c);
    logic [63:0] d;
    d = 64'(c - CH_ZERO);
    parse_phase = PH_DIGITS;
    parse_digit = 1'b1;
    if (!parse_ovf) begin
      if (64'(parse_mag) > (MAG_LIMIT - d) / 64'd10) parse_ovf = 1'b1;
      else parse_mag = VALUE_BITS'(64'(parse_mag) * 64'd10 + d);
    end
  endtask

  task automatic add_tail(input logic [CH_W-1:0] c);
    parse_phase = PH_TAIL;
    if (parse_tail == TAIL_NONE) parse_suffix = c;
    if (parse_tail != TAIL_MANY) parse_tail = parse_tail + 2'd1;
  endtask

  function automatic size_res_t scaled_size();
    size_res_t       r;
    logic [63:0]     v;
    logic [63:0]     lim;
    logic [CH_W-1:0] c;
    int              sh;
    r.size = '0;
    r.st   = ST_OK;
    v      = 64'(parse_mag);
    lim    = 64'(size_limit_m);
    sh     = 0;
    c      = parse_suffix;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CASE_GAP;
    if (!parse_digit || parse_ovf || (parse_neg && v != 0)) begin
      r.st = ST_BAD_NUMBER;
    end else if (parse_tail == TAIL_MANY) begin
      r.st = ST_EXTRA;
    end else if (parse_tail == TAIL_ONE) begin
      case (c)
        CH_K:    sh = SH_K;
        CH_M:    sh = SH_M;
        CH_G:    sh = SH_G;
        CH_T:    sh = SH_T;
        CH_P:    sh = SH_P;
        default: r.st = ST_BAD_SUFFIX;
      endcase
    end
    if (r.st == ST_OK && sh != 0) begin
      if (v > (lim >> sh)) r.st = ST_SUFFIX_OVF;
      else v = v << sh;
    end
    if (r.st == ST_OK) begin
      if (v > lim) r.st = ST_OVER_MAX;
      else r.size = v[SIZE_W-1:0];
    end
    return r;
  endfunction

  task automatic take_char(input logic [CH_W-1:0] c);
    pinned_res_t pin;
    size_res_t   res;
    if (c == CH_NUL) begin
      res = scaled_size();
      pin = pinned_q.pop_front();
      size_q.push_back(pin.fixed ? pin.res : res);
      parse_clear();
    end else begin
      case (parse_phase)
        PH_WS: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            parse_neg   = (c == CH_MINUS);
            parse_phase = PH_SIGN;
          end else if (is_numeral(c)) begin
            add_digit(c);
          end else if (!is_blank(c)) begin
            add_tail(c);
          end
        end
        PH_SIGN, PH_DIGITS: begin
          if (is_numeral(c)) add_digit(c);
          else add_tail(c);
        end
        default: add_tail(c);
      endcase
    end
  endtask

  // One process watches all three channels so that ordering within an edge is fixed.
  int idle_cycles = 0;

  always @(posedge clk) begin
    size_res_t want;
    logic      moved;
    moved = 1'b0;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        size_limit_m = cfg_if.data;
        moved = 1'b1;
      end
      if (result_if.valid && result_if.ready) begin
        moved = 1'b1;
        if (size_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got size %0d status %0d",
                   $time, result_if.size_bytes, result_if.status);
          mismatches++;
        end else begin
          want = size_q.pop_front();
          if (result_if.size_bytes !== want.size) begin
            $display("%0t: size_bytes mismatch, expected %0d, got %0d",
                     $time, want.size, result_if.size_bytes);
            mismatches++;
          end
          if (result_if.status !== want.st) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.st, result_if.status);
            mismatches++;
          end
        end
      end
      if (chars_if.valid && chars_if.ready) begin
        moved = 1'b1;
        take_char(chars_if.ch);
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // byte sender: bursts with gaps, now and then a long burst without gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      chars_if.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!chars_if.valid || chars_if.ready) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 30);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      end
      if (burst_left > 0 && char_q.size() != 0) begin
        chars_if.valid <= 1'b1;
        chars_if.ch    <= char_q.pop_front();
        burst_left--;
      end else begin
        chars_if.valid <= 1'b0;
        if (burst_left == 0 && gap_left > 0) gap_left--;
      end
    end
  end

  // result receiver: always ready, random, or periodic, plus one long hold-off
  int hold_left = 0;
  int mode_left = 0;
  int rx_mode   = 0;
  int taken     = 0;
  int tick      = 0;
  bit held      = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) taken++;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (!held && taken >= 40 && char_q.size() > 100) begin
        // input keeps coming while results back up
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        result_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (rx_mode)
          0:       result_if.ready <= 1'b1;
          1:       result_if.ready <= 1'($urandom_range(0, 1));
          default: result_if.ready <= (tick % 4 == 0);
        endcase
      end
    end
  end

  task automatic wait_idle();
    while (char_q.size() != 0 || chars_if.valid || size_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_size_limit(input logic [SIZE_W-1:0] limit);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= limit;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_row(input dir_row_t row);
    logic [CH_W-1:0] c;
    pinned_res_t     pin;
    for (int k = TEXT_LEN - 1; k >= 0; k--) begin
      c = row.text[8*k +: 8];
      if (c != CH_NUL) char_q.push_back(c);
    end
    char_q.push_back(CH_NUL);
    pin.fixed    = row.fixed;
    pin.res.size = row.size;
    pin.res.st   = row.st;
    pinned_q.push_back(pin);
  endtask

  // Mostly well-formed strings, some aimed at the size limit edges; the rest junk or followed by junk.
  task automatic add_random_string();
    int              kind;
    int              sh;
    int              idx;
    int              r;
    int              k;
    logic [63:0]     v;
    logic [CH_W-1:0] letter;
    string           digits;
    kind = $urandom_range(0, 99);
    if (kind >= 85) begin
      repeat ($urandom_range(0, 8)) char_q.push_back(CH_W'($urandom_range(1, 255)));
    end else begin
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0) begin
        r = $urandom_range(0, 5);
        char_q.push_back((r == 5) ? CH_SPACE : CH_TAB + CH_W'(r));
      end
      r = $urandom_range(0, 9);
      if (r < 2) char_q.push_back(CH_PLUS);
      else if (r == 2) char_q.push_back(CH_MINUS);
      idx    = $urandom_range(0, 9);
      letter = SUFFIX_SET[8*idx +: 8];
      sh     = ($urandom_range(0, 1) == 1) ? 10 * (idx % 5 + 1) : 0;
      case ($urandom_range(0, 5))
        0:       v = $urandom_range(0, 9999);
        1:       v = {$urandom, $urandom} >> $urandom_range(0, 63);
        2:       v = (64'(size_limit_m) >> sh) + $urandom_range(0, 2) - 1;
        3:       v = 64'(size_limit_m) + $urandom_range(0, 2) - 1;
        4:       v = MAG_LIMIT + $urandom_range(0, 2) - 1;
        default: v = '0;
      endcase
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 20)) char_q.push_back(CH_ZERO);
      end
      digits = $sformatf("%0d", v);
      for (k = 0; k < digits.len(); k++) char_q.push_back(digits[k]);
      if (sh != 0) char_q.push_back(letter);
      if (kind >= 70) begin
        repeat ($urandom_range(1, 3)) char_q.push_back(CH_W'($urandom_range(1, 255)));
      end
    end
    char_q.push_back(CH_NUL);
    pinned_q.push_back('0);
  endtask

  initial begin
    logic [SIZE_W-1:0] limit;
    int                i;
    int                p;
    chars_if.valid  = 1'b0;
    chars_if.ch     = CH_NUL;
    result_if.ready = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    size_limit_m    = SIZE_LIMIT_RESET;
    parse_clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].is_cfg) begin
        wait_idle();
        write_size_limit(dir_tab[i].size);
      end else begin
        load_row(dir_tab[i]);
      end
    end

    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       limit = SIZE_W'({$urandom, $urandom});
        1:       limit = SIZE_W'(64'd1 << $urandom_range(20, 62))
                         - SIZE_W'($urandom_range(0, 1));
        2:       limit = SIZE_W'($urandom_range(0, 100000));
        3:       limit = '0;
        4:       limit = SIZE_W'({$urandom, $urandom} >> $urandom_range(1, 40));
        default: limit = SIZE_MAX;
      endcase
      wait_idle();
      write_size_limit(limit);
      while (char_q.size() < PHASE_CHARS) add_random_string();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
